FILE: hw/rtl/ssds_pkg.sv
// ----------------------------------------------------------------------------
// ssds_pkg - shared definitions for the seven-segment decimal scanner
// Holds the microcode word layout, the program ROM and the digit patterns.
// ----------------------------------------------------------------------------
package ssds_pkg;

   localparam int STEP_W = 4;

   // Program addresses that the sequencer refers to by name.
   localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_UNITS = 4'd5;
   localparam logic [STEP_W-1:0] STEP_END   = 4'd8;

   localparam logic [13:0] DEC_MOD = 14'd10000;

   typedef enum logic [1:0] {
      OP_WAIT,
      OP_DIV,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [1:0]        idx;     // digit slot written (DIV) or shown (EMIT)
      logic [STEP_W-1:0] target;  // start of the next pass of frames
   } ctrl_word_type;

   // Program: wait for a beat, peel off four decimal digits, then emit frames.
   function automatic ctrl_word_type micro_word(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = '{op: OP_WAIT, idx: 2'd0, target: STEP_WAIT};
      case (step)
         4'd0: w = '{op: OP_WAIT, idx: 2'd0, target: STEP_WAIT};
         4'd1: w = '{op: OP_DIV,  idx: 2'd0, target: STEP_WAIT};
         4'd2: w = '{op: OP_DIV,  idx: 2'd1, target: STEP_WAIT};
         4'd3: w = '{op: OP_DIV,  idx: 2'd2, target: STEP_WAIT};
         4'd4: w = '{op: OP_DIV,  idx: 2'd3, target: STEP_WAIT};
         4'd5: w = '{op: OP_EMIT, idx: 2'd0, target: STEP_UNITS};
         4'd6: w = '{op: OP_EMIT, idx: 2'd1, target: STEP_UNITS};
         4'd7: w = '{op: OP_EMIT, idx: 2'd2, target: STEP_UNITS};
         4'd8: w = '{op: OP_EMIT, idx: 2'd3, target: STEP_UNITS};
         default: w = '{op: OP_WAIT, idx: 2'd0, target: STEP_WAIT};
      endcase
      return w;
   endfunction

   // Active-low common-anode patterns, decimal point off.
   function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
      logic [7:0] p;
      p = 8'hFF;
      case (digit)
         4'd0: p = 8'hC0;
         4'd1: p = 8'hF9;
         4'd2: p = 8'hA4;
         4'd3: p = 8'hB0;
         4'd4: p = 8'h99;
         4'd5: p = 8'h92;
         4'd6: p = 8'h82;
         4'd7: p = 8'hF8;
         4'd8: p = 8'h80;
         4'd9: p = 8'h90;
         default: p = 8'hFF;
      endcase
      return p;
   endfunction

endpackage

FILE: hw/rtl/ssds_div10.sv
// ----------------------------------------------------------------------------
// ssds_div10 - divide by ten
// Quotient by reciprocal multiply, remainder by multiply-back and subtract.
// ----------------------------------------------------------------------------
module ssds_div10 (
   input  logic [13:0] num,
   output logic [13:0] quot,
   output logic [3:0]  rem
);

   // 52429 / 2^19 is exact for every 14-bit numerator.
   logic [29:0] prod;
   logic [10:0] q;
   logic [13:0] back;

   assign prod = 30'(num) * 30'd52429;
   assign q    = prod[29:19];
   assign back = {q[10:0], 3'b000} + {2'b00, q[10:0], 1'b0};
   assign quot = {3'b000, q};
   assign rem  = 4'(num - back);

endmodule

FILE: hw/rtl/seven_segment_decimal_scanner.sv
// ----------------------------------------------------------------------------
// seven_segment_decimal_scanner - digit frames for a multiplexed display
// Turns a binary value into segment/select frames for a seven-segment panel.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one beat per value: req_tuser selects four-digit (0)
// or two-digit (1) mode, req_tdata carries the value, the leading-zero flag,
// the repeat count and the two-digit select byte. The rsp channel returns one
// beat per display frame: segment byte, digit-select byte, and rsp_tlast on
// the final frame of the burst for that value.
// The block is run by a small microcode program. After a beat is taken, four
// steps of the shared divide-by-ten unit split the value into digits, one
// digit a cycle. Then, while the receiver keeps up, one frame a cycle is
// emitted into the output register. A pass has one to four frames in
// four-digit mode, two in two-digit mode; a value gives repeats+1 passes.
// A new request is taken only while the program sits in its wait step.
// When the receiver stalls, the program holds at its emit step until the
// output register frees up; no frame is dropped or repeated.
// Reset (synchronous, active high) returns the program to the wait step and
// empties the output register.
// ----------------------------------------------------------------------------
module seven_segment_decimal_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [13:0] value, [14] show_zero, [18:15] repeats, [26:19] port_select,
   // [31:27] zero
   input  logic [31:0] req_tdata,
   // [0] kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] segments, [15:8] digit_select
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int SW = ssds_pkg::STEP_W;

   // Sequencer state.
   logic [SW-1:0] step_ff, step_in;
   ssds_pkg::ctrl_word_type cw;

   // Captured request and working registers.
   logic        kind_ff, kind_in;
   logic [3:0]  en_ff, en_in;       // bit k: frame k+1 of a pass is shown
   logic [3:0]  rep_ff, rep_in;     // passes still to go after this one
   logic [7:0]  psel_ff, psel_in;
   logic [13:0] work_ff, work_in;   // value still to be split into digits
   logic [3:0]  dig_ff [4];
   logic [3:0]  dig_in [4];

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  seg_ff, seg_in;
   logic [7:0]  sel_ff, sel_in;
   logic        last_ff, last_in;

   logic        accept;
   logic        emit_fire;
   logic        more;
   logic        frame_last;
   logic [13:0] req_value;
   logic [13:0] quot;
   logic [3:0]  rem;
   logic [3:0]  cur_digit;

   assign cw         = ssds_pkg::micro_word(step_ff);
   assign req_tready = (cw.op == ssds_pkg::OP_WAIT);
   assign accept     = req_tvalid && req_tready;
   assign req_value  = req_tdata[13:0];

   ssds_div10 u_div10 (
      .num  (work_ff),
      .quot (quot),
      .rem  (rem)
   );

   // Is another frame due in this pass after the one at cw.idx?
   assign more       = kind_ff ? (cw.idx == 2'd0) : en_ff[cw.idx];
   assign frame_last = !more && (rep_ff == 4'd0);
   assign emit_fire  = (cw.op == ssds_pkg::OP_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign cur_digit  = dig_ff[cw.idx];

   always_comb begin
      step_in      = step_ff;
      kind_in      = kind_ff;
      en_in        = en_ff;
      rep_in       = rep_ff;
      psel_in      = psel_ff;
      work_in      = work_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      seg_in       = seg_ff;
      sel_in       = sel_ff;
      last_in      = last_ff;

      case (cw.op)
         ssds_pkg::OP_WAIT: begin
            if (accept) begin
               kind_in  = req_tuser;
               rep_in   = req_tdata[18:15];
               psel_in  = req_tdata[26:19];
               en_in[0] = req_tdata[14] || (req_value > 14'd9);
               en_in[1] = req_tdata[14] || (req_value > 14'd99);
               en_in[2] = req_tdata[14] || (req_value > 14'd999);
               en_in[3] = 1'b0;
               // Fold to four decimal digits; the blanking tests above
               // use the whole value.
               work_in  = (req_value >= ssds_pkg::DEC_MOD) ?
                          (req_value - ssds_pkg::DEC_MOD) : req_value;
               step_in  = step_ff + SW'(1);
            end
         end
         ssds_pkg::OP_DIV: begin
            dig_in[cw.idx] = rem;
            work_in        = quot;
            step_in        = step_ff + SW'(1);
         end
         ssds_pkg::OP_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in = 1'b1;
               seg_in       = ssds_pkg::digit_pattern(cur_digit);
               last_in      = frame_last;
               if (kind_ff) begin
                  sel_in = (cw.idx == 2'd0) ? psel_ff : {psel_ff[6:0], 1'b0};
               end else begin
                  sel_in = 8'd1 << cw.idx;
               end
               if (more) begin
                  step_in = step_ff + SW'(1);
               end else if (rep_ff != 4'd0) begin
                  rep_in  = rep_ff - 4'd1;
                  step_in = cw.target;
               end else begin
                  step_in = ssds_pkg::STEP_WAIT;
               end
            end
         end
         default: begin
            step_in = ssds_pkg::STEP_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ssds_pkg::STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      en_ff   <= en_in;
      rep_ff  <= rep_in;
      psel_ff <= psel_in;
      work_ff <= work_in;
      dig_ff  <= dig_in;
      seg_ff  <= seg_in;
      sel_ff  <= sel_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {sel_ff, seg_ff};
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   // A taken request always starts the digit split at the first step.
   a_start_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> (step_ff == 4'd1))
      else $error("sequencer did not start digit split after request");

   // The program counter never leaves the program.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ssds_pkg::STEP_END)
      else $error("step counter outside program");

   // The working value stays a four-digit decimal number.
   a_work_range: assert property (@(posedge clock) disable iff (reset)
      (cw.op == ssds_pkg::OP_DIV) |-> (work_ff < ssds_pkg::DEC_MOD))
      else $error("working value out of decimal range");

   // Every extracted digit is a decimal digit.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (cw.op == ssds_pkg::OP_DIV) |-> (rem < 4'd10))
      else $error("divide by ten produced a bad remainder");

   // Loading the closing frame of a burst returns the program to the wait step.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && frame_last) |=> (step_ff == ssds_pkg::STEP_WAIT))
      else $error("sequencer did not return to wait after final frame");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for seven_segment_decimal_scanner
// Sends display requests over the req stream and predicts the burst of
// segment/select frames for each one. Every frame on the rsp stream is
// compared with the oldest predicted frame. Both sides idle and stall at
// random, in several phases.
// ----------------------------------------------------------------------------
module tb;

   // Display modes, carried on req_tuser.
   localparam logic KIND_FOUR = 1'b0;
   localparam logic KIND_TWO  = 1'b1;

   // Digit enables used in four-digit mode, units first.
   localparam logic [7:0] SEL_UNITS     = 8'h01;
   localparam logic [7:0] SEL_TENS      = 8'h02;
   localparam logic [7:0] SEL_HUNDREDS  = 8'h04;
   localparam logic [7:0] SEL_THOUSANDS = 8'h08;

   // Active-low glyphs for digits 0..9, digit d in bits [8*d +: 8].
   localparam logic [79:0] GLYPHS = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                     8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

   localparam int CLOCK_HALF = 6;

   typedef struct packed {
      logic        kind;
      logic [13:0] value;
      logic        show_zero;
      logic [3:0]  repeats;
      logic [7:0]  port_select;
   } display_req_type;

   typedef struct packed {
      logic [7:0] segments;
      logic [7:0] digit_select;
      logic       last;
   } frame_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [13:0] value, [14] show_zero, [18:15] repeats, [26:19] port_select,
   // [31:27] zero
   logic [31:0] req_tdata = '0;
   // [0] kind
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [7:0] segments, [15:8] digit_select
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   seven_segment_decimal_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Requests waiting to be driven, and frames the block still owes us.
   display_req_type pending_reqs[$];
   frame_type       owed_frames[$];
   display_req_type req_on_bus;
   logic            req_taken = 1'b0;

   // Idle percentages for the current phase, and the long receiver hold-off.
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic pressure_on = 1'b0;
   logic rsp_hold = 1'b0;

   int error_count = 0;
   int reqs_accepted = 0;
   int two_digit_reqs = 0;
   int frames_checked = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Works out the whole burst of frames that one request produces. The last
   // frame of the burst carries the last flag.
   task automatic predict_frames(input display_req_type rq);
      frame_type burst[$];
      frame_type f;
      int        shown;
      int        d[4];
      int        i;
      f = '0;
      if (rq.kind == KIND_FOUR) begin
         // Digits come from the value modulo 10000, but the blanking tests
         // look at the whole value, so 10000 and up always shows four digits.
         shown = rq.value % 10000;
         d[0] = shown % 10;
         d[1] = (shown / 10) % 10;
         d[2] = (shown / 100) % 10;
         d[3] = shown / 1000;
         for (int pass = 0; pass <= rq.repeats; pass++) begin
            f.segments = GLYPHS[d[0]*8 +: 8];
            f.digit_select = SEL_UNITS;
            burst.push_back(f);
            if (rq.show_zero || rq.value > 9) begin
               f.segments = GLYPHS[d[1]*8 +: 8];
               f.digit_select = SEL_TENS;
               burst.push_back(f);
            end
            if (rq.show_zero || rq.value > 99) begin
               f.segments = GLYPHS[d[2]*8 +: 8];
               f.digit_select = SEL_HUNDREDS;
               burst.push_back(f);
            end
            if (rq.show_zero || rq.value > 999) begin
               f.segments = GLYPHS[d[3]*8 +: 8];
               f.digit_select = SEL_THOUSANDS;
               burst.push_back(f);
            end
         end
      end else begin
         // Two-digit mode: value modulo 100, tens select is the units select
         // moved up one bit, with the top bit falling off.
         shown = rq.value % 100;
         for (int pass = 0; pass <= rq.repeats; pass++) begin
            f.segments = GLYPHS[(shown % 10)*8 +: 8];
            f.digit_select = rq.port_select;
            burst.push_back(f);
            f.segments = GLYPHS[(shown / 10)*8 +: 8];
            f.digit_select = {rq.port_select[6:0], 1'b0};
            burst.push_back(f);
         end
      end
      for (i = 0; i < burst.size(); i++) begin
         f = burst[i];
         f.last = (i == burst.size() - 1);
         owed_frames.push_back(f);
      end
   endtask

   // Driver: presents a new request on the falling edge once the previous
   // beat is gone, or idles at random according to the phase.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_on_bus = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= req_on_bus.kind;
            req_tdata  <= {5'b0, req_on_bus.port_select, req_on_bus.repeats,
                           req_on_bus.show_zero, req_on_bus.value};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: ready changes on the falling edge too. The long hold-off
   // overrides the random stalls.
   always @(negedge clock) begin
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
   end

   // Monitor and predictor share one rising-edge process, so an accepted
   // frame is always checked before the frames of a request taken on the
   // same edge are queued.
   always @(posedge clock) begin
      frame_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_frames.size() == 0) begin
            report_mismatch("unexpected frame", {rsp_tlast, rsp_tdata}, 0);
         end else begin
            want = owed_frames.pop_front();
            frames_checked++;
            if (rsp_tdata[7:0] !== want.segments)
               report_mismatch("segments", rsp_tdata[7:0], want.segments);
            if (rsp_tdata[15:8] !== want.digit_select)
               report_mismatch("digit_select", rsp_tdata[15:8], want.digit_select);
            if (rsp_tlast !== want.last)
               report_mismatch("last", rsp_tlast, want.last);
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         reqs_accepted++;
         if (req_on_bus.kind == KIND_TWO)
            two_digit_reqs++;
         predict_frames(req_on_bus);
      end
   end

   // Long receiver hold-off: once the pressure phase starts, ready is held
   // low while the sender keeps offering beats, so the output register
   // fills and the block stops taking requests.
   initial begin
      while (!pressure_on)
         @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   function automatic display_req_type make_req(input logic kind, input int value,
                                                input logic show_zero, input int repeats,
                                                input int port_select);
      display_req_type rq;
      rq.kind        = kind;
      rq.value       = 14'(value);
      rq.show_zero   = show_zero;
      rq.repeats     = 4'(repeats);
      rq.port_select = 8'(port_select);
      return rq;
   endfunction

   // Random request: values lean toward the blanking thresholds and small
   // numbers, repeat counts are mostly small with the odd full burst.
   function automatic display_req_type random_req();
      display_req_type rq;
      rq.kind = 1'($urandom_range(1));
      case ($urandom_range(7))
         0, 1: rq.value = 14'($urandom_range(9));
         2: rq.value = 14'($urandom_range(99));
         3: rq.value = 14'($urandom_range(999));
         4: begin
            case ($urandom_range(7))
               0: rq.value = 14'd9;
               1: rq.value = 14'd10;
               2: rq.value = 14'd99;
               3: rq.value = 14'd100;
               4: rq.value = 14'd999;
               5: rq.value = 14'd1000;
               6: rq.value = 14'd9999;
               default: rq.value = 14'd10000;
            endcase
         end
         default: rq.value = 14'($urandom_range(16383));
      endcase
      rq.show_zero = 1'($urandom_range(1));
      rq.repeats = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) :
                                              4'($urandom_range(2));
      rq.port_select = 8'($urandom_range(255));
      return rq;
   endfunction

   // Waits until every queued request has gone out and every owed frame
   // has come back.
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || owed_frames.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_phase(input int idle, input int stall, input int count);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) pending_reqs.push_back(random_req());
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: blanking thresholds in both directions, the value
      // range ends, values of 10000 and up, every digit, the longest burst,
      // and two-digit selects whose top bit falls off when shifted.
      pending_reqs.push_back(make_req(KIND_FOUR, 0, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 0, 1'b1, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 9, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 10, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 99, 1'b0, 1, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 100, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 999, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 1000, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 1234, 1'b0, 15, 255));
      pending_reqs.push_back(make_req(KIND_FOUR, 5678, 1'b1, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 9999, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 10000, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 10005, 1'b0, 2, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 16383, 1'b1, 15, 255));
      pending_reqs.push_back(make_req(KIND_FOUR, 7, 1'b1, 3, 0));
      pending_reqs.push_back(make_req(KIND_FOUR, 90, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_TWO, 0, 1'b0, 0, 0));
      pending_reqs.push_back(make_req(KIND_TWO, 99, 1'b0, 0, 8'h80));
      pending_reqs.push_back(make_req(KIND_TWO, 7, 1'b1, 0, 8'h01));
      pending_reqs.push_back(make_req(KIND_TWO, 1234, 1'b0, 1, 8'h55));
      pending_reqs.push_back(make_req(KIND_TWO, 16383, 1'b1, 15, 8'hFF));
      pending_reqs.push_back(make_req(KIND_TWO, 10056, 1'b0, 0, 8'hAA));
      drain();

      // Random phases: no idling, sender mostly idle, receiver mostly
      // stalled, then light idling on both sides.
      random_phase(0, 0, 34);
      random_phase(77, 0, 34);
      random_phase(0, 77, 34);
      random_phase(13, 13, 34);

      // Back-pressure: sender keeps offering while ready is held low.
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (12) pending_reqs.push_back(random_req());
      pressure_on = 1'b1;
      drain();

      // Let any stray frame show up before calling it.
      repeat (20) @(posedge clock);

      $display("Covered %0d requests (%0d two-digit) and %0d frames,", reqs_accepted,
               two_digit_reqs, frames_checked);
      $display("under free-running, idle-sender, stalled-receiver and back-pressure phases.");
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #12000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
